>>> src/cms_pkg.sv
// ----------------------------------------------------------------------------
// cms_pkg: shared types and codes for the capped message store
// Holds request/response payload structs, result kinds, FSM states and the
// command/status structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package cms_pkg;

   localparam int TOTAL_W = 26;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   typedef enum logic [1:0] {
      KIND_REMOVED  = 2'd0,
      KIND_ADD_DONE = 2'd1,
      KIND_REJECTED = 2'd2,
      KIND_CLEAR    = 2'd3
   } kind_type;

   typedef enum logic [0:0] {
      ACT_ADD   = 1'b0,
      ACT_CLEAR = 1'b1
   } action_type;

   typedef enum logic [0:0] {
      CSR_EXPIRY = 1'b0,
      CSR_MAXB   = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic        action;
      logic [31:0] arrival_time;
      logic [19:0] entry_bytes;
      logic        is_broadcast;
      logic [31:0] clear_limit_id;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [31:0] entry_id;
      logic [5:0]  removed_count;
      logic [25:0] stored_bytes;
      logic [5:0]  entry_count;
      logic [31:0] last_id;
      logic        last;
   } rsp_type;

   // Pass codes for the marking scan.
   typedef enum logic [2:0] {
      PASS_CLEAR  = 3'd0,
      PASS_FRESH  = 3'd1,
      PASS_EXPIRE = 3'd2,
      PASS_BCAST  = 3'd3,
      PASS_ANY    = 3'd4
   } pass_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_APPEND,
      ST_MARK,
      ST_DROP,
      ST_FINAL
   } state_type;

   typedef struct packed {
      logic     load;        // capture request
      logic     append;      // write the new record
      logic     scan_start;  // reset scan index for a pass
      logic     scan_step;   // mark one slot
      pass_type pass;
      logic     drop_start;  // reset drop read/write indexes
      logic     drop_step;   // move or remove one slot
      logic     final_beat;  // emit final result
      logic     reject_beat; // emit rejection
   } cmd_type;

   typedef struct packed {
      logic is_clear;
      logic full;
      logic above_cap;   // total after add exceeds cap
      logic expiry_on;
      logic scan_done;
      logic drop_done;
   } sts_type;

endpackage

>>> src/cms_ctrl.sv
// ----------------------------------------------------------------------------
// cms_ctrl: sequencer for the capped message store
// Walks an item through append or rejection, marking passes, the drop sweep
// and the final beat; drives the datapath with one command struct per cycle.
// ----------------------------------------------------------------------------
module cms_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  cms_pkg::sts_type  sts,
   output cms_pkg::cmd_type  cmd
);
   import cms_pkg::*;

   state_type state_ff, state_in;
   pass_type  pass_ff, pass_in;

   // Hold state and pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pass_ff  <= PASS_CLEAR;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
      end
   end

   // Sequence the passes.
   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      cmd      = '0;
      cmd.pass = pass_ff;
      busy     = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_APPEND;
            end
         end
         ST_APPEND: begin
            cmd.scan_start = 1'b1;
            if (sts.is_clear) begin
               pass_in  = PASS_CLEAR;
               state_in = ST_MARK;
            end else if (sts.full) begin
               cmd.reject_beat = 1'b1;
               state_in = ST_IDLE;
            end else begin
               cmd.append = 1'b1;
               if (!sts.above_cap) pass_in = PASS_FRESH;
               else if (sts.expiry_on) pass_in = PASS_EXPIRE;
               else pass_in = PASS_BCAST;
               state_in = ST_MARK;
            end
         end
         ST_MARK: begin
            if (sts.scan_done) begin
               cmd.scan_start = 1'b1;
               case (pass_ff)
                  PASS_EXPIRE: pass_in = PASS_BCAST;
                  PASS_BCAST:  pass_in = PASS_ANY;
                  default: begin
                     cmd.drop_start = 1'b1;
                     state_in = ST_DROP;
                  end
               endcase
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_DROP: begin
            if (sts.drop_done) state_in = ST_FINAL;
            else cmd.drop_step = 1'b1;
         end
         ST_FINAL: begin
            cmd.final_beat = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

>>> src/cms_data.sv
// ----------------------------------------------------------------------------
// cms_data: record table, totals and result formatting
// Table memories are scanned one slot a cycle; a drop sweep compacts in place.
// ----------------------------------------------------------------------------
module cms_data #(
   parameter int MAX_ENTRIES = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write,
   input  logic              csr_index,
   input  logic [31:0]       csr_data,
   input  cms_pkg::req_type  req_data,
   input  cms_pkg::cmd_type  cmd,
   output cms_pkg::sts_type  sts,
   output logic              rsp_valid,
   output cms_pkg::rsp_type  rsp_data
);
   import cms_pkg::*;

   localparam int IW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);

   logic [31:0] slot_id   [MAX_ENTRIES];
   logic [31:0] slot_time [MAX_ENTRIES];
   logic [19:0] slot_bytes[MAX_ENTRIES];
   logic        slot_bcast[MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] drop_ff;

   logic [31:0] expiry_ff;
   logic [25:0] maxb_ff;
   req_type     req_ff;
   logic [31:0] next_id_ff;
   logic [25:0] total_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] n_ff;        // records held before this add
   logic [CW-1:0] scan_ff;
   logic          stop_ff;     // in-order pass has stopped
   logic [25:0]   remain_ff;
   logic [CW-1:0] rd_ff, wr_ff;
   logic [5:0]    removed_ff;
   logic [31:0]   new_id_ff;

   // Registered slot read at the scan or drop index.
   logic [31:0] rid_ff, rtime_ff;
   logic [19:0] rbytes_ff;
   logic        rbcast_ff;
   logic        rvalid_ff;
   logic        rdrop_ff;

   logic [IW-1:0] scan_ix, rd_ix, wr_ix;
   assign scan_ix = scan_ff[IW-1:0];
   assign rd_ix   = rd_ff[IW-1:0];
   assign wr_ix   = wr_ff[IW-1:0];

   // Sum of total and new size, saturated.
   logic [26:0] add_sum;
   logic [25:0] total_add;
   assign add_sum   = {1'b0, total_ff} + {7'd0, req_ff.entry_bytes};
   assign total_add = add_sum[26] ? TOTAL_MAX : add_sum[25:0];

   // Expiry of the registered slot, without wrap.
   logic [32:0] exp_sum;
   logic        expired;
   assign exp_sum = {1'b0, rtime_ff} + {1'b0, expiry_ff};
   assign expired = (expiry_ff != '0) && (exp_sum < {1'b0, req_ff.arrival_time});

   logic [25:0] remain_sub, total_sub;
   assign remain_sub = (remain_ff > {6'd0, rbytes_ff}) ? remain_ff - {6'd0, rbytes_ff} : '0;
   assign total_sub  = (total_ff > {6'd0, rbytes_ff}) ? total_ff - {6'd0, rbytes_ff} : '0;

   logic still_over;
   assign still_over = remain_ff > maxb_ff;

   // The sweep after an add also moves the new record down.
   logic [CW-1:0] sweep_n;
   assign sweep_n = n_ff + CW'(!req_ff.action);

   assign sts.is_clear  = req_ff.action;
   assign sts.full      = (count_ff >= CW'(MAX_ENTRIES));
   assign sts.above_cap = (maxb_ff != '0) && (total_add > maxb_ff);
   assign sts.expiry_on = (expiry_ff != '0);
   assign sts.scan_done = rvalid_ff && (scan_ff == n_ff);
   assign sts.drop_done = rvalid_ff && (rd_ff == sweep_n);

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         expiry_ff <= '0;
         maxb_ff   <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_EXPIRY: expiry_ff <= csr_data;
            CSR_MAXB:   maxb_ff   <= csr_data[25:0];
            default: ;
         endcase
      end
   end

   // Read the slot under the scan or drop index.
   logic [IW-1:0] raddr;
   assign raddr = (cmd.drop_step || cmd.drop_start) ?
                  (cmd.drop_start ? '0 : IW'(rd_ff + 1'b1)) :
                  (cmd.scan_start ? '0 : IW'(scan_ff + 1'b1));
   always_ff @(posedge clock) begin
      rid_ff    <= slot_id[raddr];
      rtime_ff  <= slot_time[raddr];
      rbytes_ff <= slot_bytes[raddr];
      rbcast_ff <= slot_bcast[raddr];
      rdrop_ff  <= drop_ff[raddr];
   end

   // Write the new record or compact one kept record.
   always_ff @(posedge clock) begin
      if (cmd.append) begin
         slot_id[count_ff[IW-1:0]]    <= next_id_ff;
         slot_time[count_ff[IW-1:0]]  <= req_ff.arrival_time;
         slot_bytes[count_ff[IW-1:0]] <= req_ff.entry_bytes;
         slot_bcast[count_ff[IW-1:0]] <= req_ff.is_broadcast;
      end else if (cmd.drop_step && !rdrop_ff) begin
         slot_id[wr_ix]    <= rid_ff;
         slot_time[wr_ix]  <= rtime_ff;
         slot_bytes[wr_ix] <= rbytes_ff;
         slot_bcast[wr_ix] <= rbcast_ff;
      end
   end

   // Mark slots during scans.
   logic mark;
   always_comb begin
      mark = 1'b0;
      case (cmd.pass)
         PASS_CLEAR:  mark = !stop_ff && !(req_ff.clear_limit_id != '0 &&
                             rid_ff > req_ff.clear_limit_id);
         PASS_FRESH:  mark = !stop_ff && expired;
         PASS_EXPIRE: mark = expired;
         PASS_BCAST:  mark = !rdrop_ff && rbcast_ff && still_over;
         PASS_ANY:    mark = !rdrop_ff && still_over;
         default:     mark = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         drop_ff <= '0;
      end else if (cmd.scan_step && mark) begin
         drop_ff[scan_ix] <= 1'b1;
      end
   end

   // Sequence scan, drop and totals.
   always_ff @(posedge clock) begin
      if (reset) begin
         next_id_ff <= 32'd1;
         total_ff   <= '0;
         count_ff   <= '0;
         rvalid_ff  <= 1'b0;
         rsp_valid  <= 1'b0;
      end else begin
         rsp_valid <= (cmd.drop_step && rdrop_ff) || cmd.final_beat || cmd.reject_beat;
         rvalid_ff <= cmd.scan_start || cmd.scan_step || cmd.drop_start ||
                      cmd.drop_step;
         if (cmd.load) begin
            req_ff     <= req_data;
            n_ff       <= count_ff;
            removed_ff <= '0;
         end
         if (cmd.scan_start) begin
            scan_ff   <= '0;
            stop_ff   <= 1'b0;
            if (cmd.append) remain_ff <= total_add;
         end
         if (cmd.append) begin
            new_id_ff  <= next_id_ff;
            next_id_ff <= next_id_ff + 32'd1;
            total_ff   <= total_add;
            count_ff   <= count_ff + 1'b1;
         end
         if (cmd.scan_step) begin
            scan_ff <= scan_ff + 1'b1;
            if (!mark && (cmd.pass == PASS_CLEAR || cmd.pass == PASS_FRESH))
               stop_ff <= 1'b1;
            if (mark && cmd.pass != PASS_CLEAR && cmd.pass != PASS_FRESH)
               remain_ff <= remain_sub;
         end
         if (cmd.drop_start) begin
            rd_ff <= '0;
            wr_ff <= '0;
         end
         if (cmd.drop_step) begin
            rd_ff <= rd_ff + 1'b1;
            if (rdrop_ff) begin
               total_ff   <= total_sub;
               count_ff   <= count_ff - 1'b1;
               removed_ff <= removed_ff + 6'd1;
               rsp_data.result_kind   <= KIND_REMOVED;
               rsp_data.entry_id      <= rid_ff;
               rsp_data.removed_count <= '0;
               rsp_data.stored_bytes  <= total_sub;
               rsp_data.entry_count   <= 6'(count_ff - 1'b1);
               rsp_data.last_id       <= next_id_ff - 32'd1;
               rsp_data.last          <= 1'b0;
            end else begin
               wr_ff <= wr_ff + 1'b1;
            end
         end
         if (cmd.final_beat || cmd.reject_beat) begin
            rsp_data.result_kind   <= cmd.reject_beat ? KIND_REJECTED :
                                      (req_ff.action ? KIND_CLEAR : KIND_ADD_DONE);
            rsp_data.entry_id      <= (cmd.final_beat && !req_ff.action) ? new_id_ff : '0;
            rsp_data.removed_count <= cmd.reject_beat ? '0 : removed_ff;
            rsp_data.stored_bytes  <= total_ff;
            rsp_data.entry_count   <= 6'(count_ff);
            rsp_data.last_id       <= next_id_ff - 32'd1;
            rsp_data.last          <= 1'b1;
         end
      end
   end

endmodule

>>> src/capped_message_store_eviction.sv
// Capped message store: one item in flight at a time.
// A rejected add goes back to idle with its result; a clear runs one marking
// scan and an add one, or two or three when over the cap (three with expiry
// on), then one drop sweep, one slot a cycle through the table port.
// busy falls as the final beat shows, and a new item can then be accepted; the
// receiver cannot stall. Synchronous reset empties table and totals, next id 1.
module capped_message_store_eviction #(
   parameter int MAX_ENTRIES = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  cms_pkg::req_type req_data,
   output logic             rsp_valid,
   output cms_pkg::rsp_type rsp_data,
   input  logic             csr_write,
   input  logic             csr_index,
   input  logic [31:0]      csr_data
);
   import cms_pkg::*;

   cmd_type cmd;
   sts_type sts;

   cms_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .sts(sts), .cmd(cmd)
   );

   cms_data #(.MAX_ENTRIES(MAX_ENTRIES)) u_data (
      .clock(clock), .reset(reset), .csr_write(csr_write),
      .csr_index(csr_index), .csr_data(csr_data), .req_data(req_data),
      .cmd(cmd), .sts(sts), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

endmodule

>>> src/cms_check.sv
// ----------------------------------------------------------------------------
// cms_check: port-level checks for the capped message store
// Watches start/busy and the result strobe over time.
// ----------------------------------------------------------------------------
module cms_check (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input cms_pkg::rsp_type rsp_data
);
   import cms_pkg::*;

   // Accepted item makes the block busy.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("not busy after accept");

   // No result while idle and no item pending.
   a_no_stray: assert property (@(posedge clock) disable iff (reset)
      !busy && !$past(busy) |-> !rsp_valid) else $error("stray result");

   // Final beat carries a non-removal kind.
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |-> rsp_data.result_kind != KIND_REMOVED)
      else $error("final beat kind");

   // Entry count bounded.
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.entry_count <= 6'd63) else $error("count");

endmodule

bind capped_message_store_eviction cms_check u_check (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_data(rsp_data)
);
